### rtl/business_day_date_advance_assert.svh
// Assertion macros shared by the business day date advance RTL.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef BUSINESS_DAY_DATE_ADVANCE_ASSERT_SVH
`define BUSINESS_DAY_DATE_ADVANCE_ASSERT_SVH

// Property that must hold in the same cycle as its antecedent.
`define BDDA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold in the cycle after its antecedent.
`define BDDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bdda_pkg.sv
// Shared types, constants and calendar functions for the business day date advance block.
// No dependencies.
package bdda_pkg;

    localparam int YEAR_W  = 14;
    localparam int YEAR_IW = 15;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 12;
    localparam int WD_W    = 3;
    localparam int YMOD_W  = 9;
    localparam int Q400_W  = 7;
    localparam int ACC_W   = 15;

    // Division by 400 as a multiply by 20972 and a shift by 23, exact for
    // every dividend below 32768.
    localparam int YDIV_MUL    = 20972;
    localparam int YDIV_SHIFT  = 23;
    localparam int DIV_PROD_W  = 30;

    localparam int MAX_BUSINESS_DAYS_DEF = 4095;

    localparam logic [MONTH_W-1:0] MONTH_JAN      = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB      = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC      = 4'd12;
    localparam logic [WD_W-1:0]    WD_SUNDAY      = 3'd0;
    localparam logic [WD_W-1:0]    WD_FRIDAY      = 3'd5;
    localparam logic [WD_W-1:0]    WD_SATURDAY    = 3'd6;
    localparam logic [YMOD_W-1:0]  YMOD_LAST      = 9'd399;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SPLIT,
        ST_MOD,
        ST_WALK,
        ST_DONE
    } bdda_state_t;

    typedef struct packed {
        logic load;
        logic reduce;
        logic split;
        logic mod_step;
        logic walk;
    } bdda_cmd_t;

    typedef struct packed {
        logic invalid;
        logic zero_count;
        logic walk_last;
    } bdda_stat_t;

    // Leap test from the year modulo 400.
    function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
        is_leap = (ymod[1:0] == 2'd0) && (ymod != 9'd100) && (ymod != 9'd200)
                  && (ymod != 9'd300);
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        month_days = len;
    endfunction

    // floor(31 * mm / 12) with March as the first month of the shifted year.
    function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] off;
        case (m)
            4'd1:    off = 5'd28;
            4'd2:    off = 5'd31;
            4'd3:    off = 5'd2;
            4'd4:    off = 5'd5;
            4'd5:    off = 5'd7;
            4'd6:    off = 5'd10;
            4'd7:    off = 5'd12;
            4'd8:    off = 5'd15;
            4'd9:    off = 5'd18;
            4'd10:   off = 5'd20;
            4'd11:   off = 5'd23;
            4'd12:   off = 5'd25;
            default: off = 5'd0;
        endcase
        month_offset = off;
    endfunction

endpackage

### rtl/bdda_ctrl.sv
// Sequencer for the business day date advance block.
// Depends on bdda_pkg for the state, command and status types.
module bdda_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  bdda_pkg::bdda_stat_t stat,
    output bdda_pkg::bdda_cmd_t  cmd,
    output logic                busy,
    output logic                done
);

    bdda_pkg::bdda_state_t state_reg;
    bdda_pkg::bdda_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdda_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            bdda_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = bdda_pkg::ST_REDUCE;
                end
            end
            bdda_pkg::ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                state_next = bdda_pkg::ST_SPLIT;
            end
            bdda_pkg::ST_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = stat.invalid ? bdda_pkg::ST_DONE : bdda_pkg::ST_MOD;
            end
            bdda_pkg::ST_MOD:
            begin
                cmd.mod_step = 1'b1;
                state_next   = stat.zero_count ? bdda_pkg::ST_DONE : bdda_pkg::ST_WALK;
            end
            bdda_pkg::ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = bdda_pkg::ST_DONE;
                end
            end
            bdda_pkg::ST_DONE:
            begin
                state_next = bdda_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bdda_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != bdda_pkg::ST_IDLE);
    assign done = (state_reg == bdda_pkg::ST_DONE);

endmodule

### rtl/bdda_dp.sv
// Datapath of the business day date advance block: year reduction, weekday
// computation, and the one-day-per-cycle calendar walk. Depends on bdda_pkg.
module bdda_dp #(
    parameter int MAX_BUSINESS_DAYS = bdda_pkg::MAX_BUSINESS_DAYS_DEF
) (
    input  logic                              clk,
    input  bdda_pkg::bdda_cmd_t               cmd,
    output bdda_pkg::bdda_stat_t              stat,
    input  logic [bdda_pkg::YEAR_W-1:0]       start_year,
    input  logic [bdda_pkg::MONTH_W-1:0]      start_month,
    input  logic [bdda_pkg::DAY_W-1:0]        start_day,
    input  logic [bdda_pkg::COUNT_W-1:0]      business_days,
    output logic [bdda_pkg::YEAR_W-1:0]       end_year,
    output logic [bdda_pkg::MONTH_W-1:0]      end_month,
    output logic [bdda_pkg::DAY_W-1:0]        end_day,
    output logic [bdda_pkg::WD_W-1:0]         end_weekday,
    output logic [bdda_pkg::WD_W-1:0]         start_weekday,
    output logic                              date_invalid
);

    localparam int CNT_W = $clog2(MAX_BUSINESS_DAYS + 1);
    localparam int CMP_W = (CNT_W > bdda_pkg::COUNT_W) ? CNT_W : bdda_pkg::COUNT_W;
    localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_BUSINESS_DAYS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BUSINESS_DAYS);

    logic [bdda_pkg::YEAR_IW-1:0] year_reg,    year_next;
    logic [bdda_pkg::MONTH_W-1:0] month_reg,   month_next;
    logic [bdda_pkg::DAY_W-1:0]   day_reg,     day_next;
    logic [CNT_W-1:0]             target_reg,  target_next;
    logic [CNT_W-1:0]             cnt_reg,     cnt_next;
    logic [bdda_pkg::YEAR_IW-1:0] rem_reg,     rem_next;
    logic [bdda_pkg::Q400_W-1:0]  q400_reg,    q400_next;
    logic                         early_reg,   early_next;
    logic [bdda_pkg::YMOD_W-1:0]  ymod_reg,    ymod_next;
    logic [bdda_pkg::ACC_W-1:0]   acc_reg,     acc_next;
    logic [bdda_pkg::WD_W-1:0]    wd_reg,      wd_next;
    logic [bdda_pkg::WD_W-1:0]    wd0_reg,     wd0_next;
    logic                         invalid_reg, invalid_next;

    logic [CMP_W-1:0]                bd_ext;
    logic [bdda_pkg::DIV_PROD_W-1:0] div_prod;
    logic [bdda_pkg::Q400_W-1:0]     q400_calc;
    logic [bdda_pkg::YEAR_IW-1:0]    rem_calc;
    logic [1:0]                      q100;
    logic [bdda_pkg::YMOD_W-1:0]     r100;
    logic [bdda_pkg::YMOD_W-1:0]     ymod_sum;
    logic [bdda_pkg::YMOD_W-1:0]     ymod_start;
    logic [bdda_pkg::DAY_W-1:0]      start_len;
    logic                            invalid_c;
    logic [15:0]                     wd_sum;
    logic [5:0]                      fold1;
    logic [3:0]                      fold2;
    logic [bdda_pkg::WD_W-1:0]       wd_mod;
    logic                            business;
    logic [CNT_W-1:0]                cnt_inc;
    logic [bdda_pkg::DAY_W-1:0]      walk_len;

    always_comb
    begin
        bd_ext = CMP_W'(business_days);
        if (bd_ext > MAX_CMP)
        begin
            target_next = MAX_CNT;
        end
        else
        begin
            target_next = bd_ext[CNT_W-1:0];
        end
    end

    // Quotient and remainder of the shifted year by 400 in one step.
    assign div_prod  = bdda_pkg::DIV_PROD_W'(rem_reg)
                       * bdda_pkg::DIV_PROD_W'(bdda_pkg::YDIV_MUL);
    assign q400_calc = div_prod[bdda_pkg::DIV_PROD_W-1:bdda_pkg::YDIV_SHIFT];
    assign rem_calc  = rem_reg - bdda_pkg::YEAR_IW'(q400_calc) * 15'd400;

    // Split the reduced year into hundreds and the remainder below 100.
    always_comb
    begin
        if (rem_reg >= 15'd300)
        begin
            q100 = 2'd3;
        end
        else if (rem_reg >= 15'd200)
        begin
            q100 = 2'd2;
        end
        else if (rem_reg >= 15'd100)
        begin
            q100 = 2'd1;
        end
        else
        begin
            q100 = 2'd0;
        end
        r100     = rem_reg[bdda_pkg::YMOD_W-1:0] - 9'(q100) * 9'd100;
        ymod_sum = rem_reg[bdda_pkg::YMOD_W-1:0] + 9'(early_reg);
        ymod_start = (ymod_sum == 9'd400) ? 9'd0 : ymod_sum;
        start_len  = bdda_pkg::month_days(month_reg, bdda_pkg::is_leap(ymod_start));
        invalid_c  = (year_reg == '0) || (month_reg == '0)
                     || (month_reg > bdda_pkg::MONTH_DEC) || (day_reg == '0)
                     || (day_reg > start_len);
        // yy + yy/4 - yy/100 + yy/400 collapses to 497*q400 + r + 24*q100 + r100/4.
        wd_sum = 16'(day_reg) + 16'(q400_reg) * 16'd497 + 16'(rem_reg)
                 + 16'(q100) * 16'd24 + 16'(r100[6:2])
                 + 16'(bdda_pkg::month_offset(month_reg));
    end

    // Modulo 7 by folding octal digits, since 8 is 1 modulo 7.
    assign fold1  = 6'(acc_reg[2:0]) + 6'(acc_reg[5:3]) + 6'(acc_reg[8:6])
                    + 6'(acc_reg[11:9]) + 6'(acc_reg[14:12]);
    assign fold2  = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    assign wd_mod = (fold2 >= 4'd7) ? bdda_pkg::WD_W'(fold2 - 4'd7)
                                    : fold2[bdda_pkg::WD_W-1:0];

    assign business = (wd_reg != bdda_pkg::WD_FRIDAY) && (wd_reg != bdda_pkg::WD_SATURDAY);
    assign cnt_inc  = cnt_reg + CNT_W'(business);
    assign walk_len = bdda_pkg::month_days(month_reg, bdda_pkg::is_leap(ymod_reg));

    always_comb
    begin
        year_next    = year_reg;
        month_next   = month_reg;
        day_next     = day_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        q400_next    = q400_reg;
        early_next   = early_reg;
        ymod_next    = ymod_reg;
        acc_next     = acc_reg;
        wd_next      = wd_reg;
        wd0_next     = wd0_reg;
        invalid_next = invalid_reg;

        if (cmd.load)
        begin
            year_next    = bdda_pkg::YEAR_IW'(start_year);
            month_next   = start_month;
            day_next     = start_day;
            cnt_next     = '0;
            early_next   = (start_month <= bdda_pkg::MONTH_FEB);
            rem_next     = bdda_pkg::YEAR_IW'(start_year)
                           - bdda_pkg::YEAR_IW'(start_month <= bdda_pkg::MONTH_FEB);
            q400_next    = '0;
            invalid_next = 1'b0;
        end

        if (cmd.reduce)
        begin
            rem_next  = rem_calc;
            q400_next = q400_calc;
        end

        if (cmd.split)
        begin
            ymod_next    = ymod_start;
            invalid_next = invalid_c;
            acc_next     = wd_sum[bdda_pkg::ACC_W-1:0];
        end

        if (cmd.mod_step)
        begin
            wd_next  = wd_mod;
            wd0_next = wd_mod;
        end

        if (cmd.walk)
        begin
            cnt_next = cnt_inc;
            if (cnt_inc < target_reg)
            begin
                wd_next = (wd_reg == bdda_pkg::WD_SATURDAY) ? bdda_pkg::WD_SUNDAY
                                                            : wd_reg + 3'd1;
                if (day_reg == walk_len)
                begin
                    day_next = 5'd1;
                    if (month_reg == bdda_pkg::MONTH_DEC)
                    begin
                        month_next = bdda_pkg::MONTH_JAN;
                        year_next  = year_reg + 15'd1;
                        ymod_next  = (ymod_reg == bdda_pkg::YMOD_LAST) ? 9'd0
                                                                       : ymod_reg + 9'd1;
                    end
                    else
                    begin
                        month_next = month_reg + 4'd1;
                    end
                end
                else
                begin
                    day_next = day_reg + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg    <= year_next;
        month_reg   <= month_next;
        day_reg     <= day_next;
        cnt_reg     <= cnt_next;
        rem_reg     <= rem_next;
        q400_reg    <= q400_next;
        early_reg   <= early_next;
        ymod_reg    <= ymod_next;
        acc_reg     <= acc_next;
        wd_reg      <= wd_next;
        wd0_reg     <= wd0_next;
        invalid_reg <= invalid_next;
        if (cmd.load)
        begin
            target_reg <= target_next;
        end
    end

    assign stat.invalid     = invalid_c;
    assign stat.zero_count  = (target_reg == '0);
    assign stat.walk_last   = (cnt_inc >= target_reg);

    assign end_year      = year_reg[bdda_pkg::YEAR_W-1:0];
    assign end_month     = month_reg;
    assign end_day       = day_reg;
    assign end_weekday   = invalid_reg ? bdda_pkg::WD_SUNDAY : wd_reg;
    assign start_weekday = invalid_reg ? bdda_pkg::WD_SUNDAY : wd0_reg;
    assign date_invalid  = invalid_reg;

endmodule

### rtl/business_day_date_advance.sv
// Top level of the business day date advance block: sequencer plus datapath.
// Depends on bdda_pkg, bdda_ctrl, bdda_dp and business_day_date_advance_assert.svh.
//
//   Channel   Handshake          Payload ports
//   --------  -----------------  --------------------------------------------------
//   command   start / busy       start_year, start_month, start_day, business_days
//   result    done (strobe)      end_year, end_month, end_day, end_weekday,
//                                start_weekday, date_invalid
//
// A transaction is taken at a clock edge where start is high and busy is low.
// After that edge come the year division, the split, the modulo 7 step, the
// day walk and the result strobe, in that order; an invalid date skips
// modulo and walk, a zero count skips the walk. The largest count walks
// about 5733 days.
// Reset is asynchronous and active low and returns the sequencer to idle.
// The result strobe done is high for exactly one cycle; the receiver cannot stall.
`include "business_day_date_advance_assert.svh"

module business_day_date_advance #(
    parameter int MAX_BUSINESS_DAYS = bdda_pkg::MAX_BUSINESS_DAYS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [bdda_pkg::YEAR_W-1:0]   start_year,
    input  logic [bdda_pkg::MONTH_W-1:0]  start_month,
    input  logic [bdda_pkg::DAY_W-1:0]    start_day,
    input  logic [bdda_pkg::COUNT_W-1:0]  business_days,
    output logic                          done,
    output logic [bdda_pkg::YEAR_W-1:0]   end_year,
    output logic [bdda_pkg::MONTH_W-1:0]  end_month,
    output logic [bdda_pkg::DAY_W-1:0]    end_day,
    output logic [bdda_pkg::WD_W-1:0]     end_weekday,
    output logic [bdda_pkg::WD_W-1:0]     start_weekday,
    output logic                          date_invalid
);

    // The sequencer and datapath talk only through these two bundles.
    bdda_pkg::bdda_cmd_t  cmd;
    bdda_pkg::bdda_stat_t stat;

    // The sequencer steps through load, year reduction, weekday computation,
    // the calendar walk and the result cycle, one transaction at a time.
    bdda_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // The datapath holds the running date, the business day count and the weekday.
    // Its registers drive the result ports, the weekdays forced to Sunday on an invalid
    // date, and they stay still while done is high because the sequencer issues no command then.
    bdda_dp #(
        .MAX_BUSINESS_DAYS (MAX_BUSINESS_DAYS)
    ) u_dp (
        .clk           (clk),
        .cmd           (cmd),
        .stat          (stat),
        .start_year    (start_year),
        .start_month   (start_month),
        .start_day     (start_day),
        .business_days (business_days),
        .end_year      (end_year),
        .end_month     (end_month),
        .end_day       (end_day),
        .end_weekday   (end_weekday),
        .start_weekday (start_weekday),
        .date_invalid  (date_invalid)
    );

    // An accepted transaction must leave the idle state at once.
    `BDDA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction left busy low")
    // The result strobe lasts a single cycle and the block is then idle.
    `BDDA_ASSERT_NEXT(a_done_single, done, !done && !busy, "result strobe longer than one cycle")
    // An invalid start date reports both weekdays as zero.
    `BDDA_ASSERT_SAME(a_invalid_wd, done && date_invalid,
        end_weekday == bdda_pkg::WD_SUNDAY && start_weekday == bdda_pkg::WD_SUNDAY,
        "invalid date reported a nonzero weekday")
    // A valid result carries weekdays in the range Sunday through Saturday.
    `BDDA_ASSERT_SAME(a_wd_range, done && !date_invalid,
        end_weekday <= bdda_pkg::WD_SATURDAY && start_weekday <= bdda_pkg::WD_SATURDAY,
        "weekday out of range")

endmodule

### tb/tb_business_day_date_advance.sv
// Self-checking testbench for business_day_date_advance.
// It depends on bdda_pkg for the port widths and weekday codes, and on the RTL top level.
// Directed table first, then random commands, checked against typed results or a local date-walk predictor.
module tb_business_day_date_advance;

    // The limit below is several times the slowest correct run, about 100 commands
    // that each take the longest day walk.
    localparam int LIMIT_CYCLES  = 3_000_000;
    // The drain time after the last result watches for spurious strobes with margin.
    localparam int DRAIN_CYCLES  = 100;
    localparam int RANDOM_ITEMS  = 80;
    // The sender waits for an empty result store before this random command.
    localparam int PAUSE_ITEM    = 50;
    // Random commands in this window are sent back to back without idle cycles.
    localparam int BURST_FIRST   = 20;
    localparam int BURST_LAST    = 35;

    // One predicted result transaction.
    typedef struct {
        logic [bdda_pkg::YEAR_W-1:0]  year;
        logic [bdda_pkg::MONTH_W-1:0] month;
        logic [bdda_pkg::DAY_W-1:0]   day;
        logic [bdda_pkg::WD_W-1:0]    end_wd;
        logic [bdda_pkg::WD_W-1:0]    start_wd;
        logic                         invalid;
    } end_date_t;

    // One row of the directed table.  When has_exp is set the expected result
    // is typed into the row, otherwise the predictor supplies it.
    typedef struct {
        logic [bdda_pkg::YEAR_W-1:0]  year;
        logic [bdda_pkg::MONTH_W-1:0] month;
        logic [bdda_pkg::DAY_W-1:0]   day;
        logic [bdda_pkg::COUNT_W-1:0] count;
        bit                           has_exp;
        end_date_t                    exp;
    } date_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [bdda_pkg::YEAR_W-1:0]    start_year = '0;
    logic [bdda_pkg::MONTH_W-1:0]   start_month = '0;
    logic [bdda_pkg::DAY_W-1:0]     start_day = '0;
    logic [bdda_pkg::COUNT_W-1:0]   business_days = '0;
    logic                           done;
    logic [bdda_pkg::YEAR_W-1:0]    end_year;
    logic [bdda_pkg::MONTH_W-1:0]   end_month;
    logic [bdda_pkg::DAY_W-1:0]     end_day;
    logic [bdda_pkg::WD_W-1:0]      end_weekday;
    logic [bdda_pkg::WD_W-1:0]      start_weekday;
    logic                           date_invalid;

    // Expected results in the order their commands were accepted.
    end_date_t expected_end_dates[$];
    date_row_t directed_rows[$];
    int        mismatches = 0;
    int        cycle_count = 0;

    business_day_date_advance DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .start_year    (start_year),
        .start_month   (start_month),
        .start_day     (start_day),
        .business_days (business_days),
        .done          (done),
        .end_year      (end_year),
        .end_month     (end_month),
        .end_day       (end_day),
        .end_weekday   (end_weekday),
        .start_weekday (start_weekday),
        .date_invalid  (date_invalid)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gregorian month length, with the 4/100/400 leap rule for February.
    function automatic int month_length(input int y, input int m);
        bit leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            2:           return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:     return 31;
        endcase
    endfunction

    // Day of week with the year shifted to start in March, 0 is Sunday.
    // The caller guarantees a year of at least 1 and a month of 1 to 12.
    function automatic int weekday_from_date(input int y, input int m, input int d);
        int a;
        int yy;
        int mm;
        a  = (14 - m) / 12;
        yy = y - a;
        mm = m + 12 * a - 2;
        return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
    endfunction

    // Predicts the result of one command: walk forward a calendar day at a
    // time, counting every day that is not a Friday or a Saturday, and stop
    // on the day that brings the count to the requested number.
    function automatic end_date_t advance_date(input logic [bdda_pkg::YEAR_W-1:0] y0,
                                               input logic [bdda_pkg::MONTH_W-1:0] m0,
                                               input logic [bdda_pkg::DAY_W-1:0] d0,
                                               input logic [bdda_pkg::COUNT_W-1:0] n0);
        end_date_t r;
        int y;
        int m;
        int d;
        int n;
        int wd;
        int counted;
        y = int'(y0);
        m = int'(m0);
        d = int'(d0);
        n = int'(n0);
        if (n > bdda_pkg::MAX_BUSINESS_DAYS_DEF)
            n = bdda_pkg::MAX_BUSINESS_DAYS_DEF;
        // An invalid start date is echoed with both weekdays cleared.
        if (y == 0 || m == 0 || m > 12 || d == 0 || d > month_length(y, m))
        begin
            r.year     = y0;
            r.month    = m0;
            r.day      = d0;
            r.end_wd   = '0;
            r.start_wd = '0;
            r.invalid  = 1'b1;
            return r;
        end
        wd = weekday_from_date(y, m, d);
        r.start_wd = wd[bdda_pkg::WD_W-1:0];
        counted = 0;
        while (counted < n)
        begin
            if (wd != int'(bdda_pkg::WD_FRIDAY) && wd != int'(bdda_pkg::WD_SATURDAY))
                counted++;
            if (counted < n)
            begin
                if (d == month_length(y, m))
                begin
                    d = 1;
                    if (m == 12)
                    begin
                        m = 1;
                        y++;
                    end
                    else
                        m++;
                end
                else
                    d++;
                wd = (wd + 1) % 7;
            end
        end
        // Years past the field width wrap, since only the low bits are kept.
        r.year    = y[bdda_pkg::YEAR_W-1:0];
        r.month   = m[bdda_pkg::MONTH_W-1:0];
        r.day     = d[bdda_pkg::DAY_W-1:0];
        r.end_wd  = wd[bdda_pkg::WD_W-1:0];
        r.invalid = 1'b0;
        return r;
    endfunction

    function automatic void check_field(input string name, input int exp_val,
                                        input int act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    function automatic void add_row(input int y, input int m, input int d, input int n,
                                    input bit has_exp, input int ey, input int em,
                                    input int ed, input int ewd, input int swd,
                                    input bit inv);
        date_row_t row;
        row.year         = bdda_pkg::YEAR_W'(y);
        row.month        = bdda_pkg::MONTH_W'(m);
        row.day          = bdda_pkg::DAY_W'(d);
        row.count        = bdda_pkg::COUNT_W'(n);
        row.has_exp      = has_exp;
        row.exp.year     = bdda_pkg::YEAR_W'(ey);
        row.exp.month    = bdda_pkg::MONTH_W'(em);
        row.exp.day      = bdda_pkg::DAY_W'(ed);
        row.exp.end_wd   = bdda_pkg::WD_W'(ewd);
        row.exp.start_wd = bdda_pkg::WD_W'(swd);
        row.exp.invalid  = inv;
        directed_rows.push_back(row);
    endfunction

    // Sends one command transaction.  After the idle gap, start and the
    // payload are raised and held until an edge where busy is low.  The
    // expected result is stored at that accepting edge.  A following command
    // with no gap keeps start high, so start gets one assignment per step.
    task automatic issue_command(input logic [bdda_pkg::YEAR_W-1:0] y,
                                 input logic [bdda_pkg::MONTH_W-1:0] m,
                                 input logic [bdda_pkg::DAY_W-1:0] d,
                                 input logic [bdda_pkg::COUNT_W-1:0] n,
                                 input end_date_t exp, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        start_year    <= y;
        start_month   <= m;
        start_day     <= d;
        business_days <= n;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_end_dates.push_back(exp);
    endtask

    // Waits until every expected result has come.  The store is checked on
    // the falling edge so that pops made at the rising edge are settled.
    task automatic wait_for_results();
        while (expected_end_dates.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Result monitor.  The receiver cannot stall, so every cycle with done
    // high is one result transaction, compared with the oldest expectation.
    always @(posedge clk)
    begin
        end_date_t exp;
        if (rst_n && done)
        begin
            if (expected_end_dates.size() == 0)
            begin
                $error("result transaction with no command outstanding");
                mismatches++;
            end
            else
            begin
                exp = expected_end_dates.pop_front();
                check_field("end_year", int'(exp.year), int'(end_year));
                check_field("end_month", int'(exp.month), int'(end_month));
                check_field("end_day", int'(exp.day), int'(end_day));
                check_field("end_weekday", int'(exp.end_wd), int'(end_weekday));
                check_field("start_weekday", int'(exp.start_wd), int'(start_weekday));
                check_field("date_invalid", int'(exp.invalid), int'(date_invalid));
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic [bdda_pkg::YEAR_W-1:0]  y;
        logic [bdda_pkg::MONTH_W-1:0] m;
        logic [bdda_pkg::DAY_W-1:0]   d;
        logic [bdda_pkg::COUNT_W-1:0] n;
        end_date_t                    exp;
        int                           kind;
        int                           len;
        int                           gap;

        // Directed table.  Rows with a typed result: a zero count returns the
        // start date with both weekdays equal (1 January of year 1 and of
        // 2024 are Mondays), and an invalid start date is echoed with the
        // flag set and both weekdays zero.
        add_row(1, 1, 1, 0, 1, 1, 1, 1, 1, 1, 0);
        add_row(2024, 1, 1, 0, 1, 2024, 1, 1, 1, 1, 0);
        add_row(0, 1, 1, 5, 1, 0, 1, 1, 0, 0, 1);
        add_row(2023, 0, 10, 3, 1, 2023, 0, 10, 0, 0, 1);
        add_row(2023, 13, 5, 3, 1, 2023, 13, 5, 0, 0, 1);
        add_row(2023, 15, 31, 4095, 1, 2023, 15, 31, 0, 0, 1);
        add_row(2023, 5, 0, 7, 1, 2023, 5, 0, 0, 0, 1);
        add_row(2023, 2, 29, 1, 1, 2023, 2, 29, 0, 0, 1);
        add_row(1900, 2, 29, 1, 1, 1900, 2, 29, 0, 0, 1);
        add_row(2023, 4, 31, 2, 1, 2023, 4, 31, 0, 0, 1);
        add_row(2024, 2, 30, 1, 1, 2024, 2, 30, 0, 0, 1);
        add_row(16383, 15, 31, 4095, 1, 16383, 15, 31, 0, 0, 1);
        // Rows left to the predictor: leap days, weekend starts, a one-day
        // count on a business day, rollovers and the largest counts, including
        // a walk past year 9999 and one that wraps the year field.
        add_row(2000, 2, 29, 1, 0, 0, 0, 0, 0, 0, 0);
        add_row(2024, 2, 29, 10, 0, 0, 0, 0, 0, 0, 0);
        add_row(2000, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0);
        add_row(2024, 1, 5, 1, 0, 0, 0, 0, 0, 0, 0);
        add_row(2024, 1, 4, 1, 0, 0, 0, 0, 0, 0, 0);
        add_row(2023, 12, 31, 3, 0, 0, 0, 0, 0, 0, 0);
        add_row(2100, 2, 28, 30, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, 1, 1, 4095, 0, 0, 0, 0, 0, 0, 0);
        add_row(9999, 12, 31, 4095, 0, 0, 0, 0, 0, 0, 0);
        add_row(16383, 12, 31, 4095, 0, 0, 0, 0, 0, 0, 0);

        // Reset is held from time zero and released once.
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].has_exp)
                exp = directed_rows[i].exp;
            else
                exp = advance_date(directed_rows[i].year, directed_rows[i].month,
                                   directed_rows[i].day, directed_rows[i].count);
            issue_command(directed_rows[i].year, directed_rows[i].month,
                          directed_rows[i].day, directed_rows[i].count, exp,
                          $urandom_range(0, 9));
        end

        // Random commands.  Most are well formed dates, since only those reach
        // the day walk.  The rest sit just past a month end, or are raw noise
        // over the whole field ranges.  Most counts are short to keep the run
        // brief, and a few reach the longest walks.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            kind = $urandom_range(0, 99);
            m = bdda_pkg::MONTH_W'($urandom_range(1, 12));
            case ($urandom_range(0, 9))
                0:       y = bdda_pkg::YEAR_W'(100 * $urandom_range(1, 99));
                1, 2:    y = bdda_pkg::YEAR_W'($urandom_range(1, 16383));
                default: y = bdda_pkg::YEAR_W'($urandom_range(1, 9999));
            endcase
            len = month_length(int'(y), int'(m));
            if (kind < 75)
                d = bdda_pkg::DAY_W'($urandom_range(1, len));
            else if (kind < 88)
                d = (len == 31) ? '0 : bdda_pkg::DAY_W'($urandom_range(len + 1, 31));
            else
            begin
                y = bdda_pkg::YEAR_W'($urandom_range(0, 16383));
                m = bdda_pkg::MONTH_W'($urandom_range(0, 15));
                d = bdda_pkg::DAY_W'($urandom_range(0, 31));
            end
            kind = $urandom_range(0, 99);
            if (kind < 80)
                n = bdda_pkg::COUNT_W'($urandom_range(0, 40));
            else if (kind < 95)
                n = bdda_pkg::COUNT_W'($urandom_range(41, 600));
            else
                n = bdda_pkg::COUNT_W'($urandom_range(601, 4095));

            // Start drops at the edge that took the previous command, so the
            // idle block does not take it a second time during the pause.
            if (i == PAUSE_ITEM)
            begin
                start <= 1'b0;
                wait_for_results();
            end
            if (i >= BURST_FIRST && i <= BURST_LAST)
                gap = 0;
            else
                gap = $urandom_range(0, 9);
            issue_command(y, m, d, n, advance_date(y, m, d, n), gap);
        end
        start <= 1'b0;

        // Drain the outstanding results, then watch a little longer for
        // spurious strobes.
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
